// ----- hdl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
// No dependencies; compiled first.
`default_nettype none

package sfr_pkg;

  // Text character
  localparam int CHAR_W = 16;
  typedef logic [CHAR_W-1:0] char_t;

  // Replacement is at most four characters
  localparam int SUBST_MAX = 4;
  localparam int LEN_W     = 3;

  // Result buffer holds the most results one item can cause
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PATTERN_LEN   = 2'd0;
  localparam cfg_idx_t REG_PATTERN_CHARS = 2'd1;
  localparam cfg_idx_t REG_SUBST_LEN     = 2'd2;
  localparam cfg_idx_t REG_SUBST_CHARS   = 2'd3;

  // One buffered result
  typedef struct packed {
    char_t ch;
    logic  valid;
    logic  last;
  } res_entry_t;

endpackage

`default_nettype wire

// ----- hdl/sfr_if.sv -----
// Valid/ready channel interfaces for the input and result streams.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_in_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t in_char;
  logic  in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  out_valid;
  logic  out_last;

  modport source (output valid, output out_char, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_char, input out_valid, input out_last,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/stream_find_replace.sv -----
// Stream find-and-replace: top level with match window and result buffer.
// Depends on sfr_pkg and the channel interfaces in sfr_if.sv.
// A character that produces a result is visible in the cycle after its transfer.
// Throughput: one input item per cycle while each item yields at most one result and
//   the output is ready; an item yielding more results holds off the next item.
// Reset (rst_n low, synchronous): registers zero, window and result buffer empty.
`default_nettype none

module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  sfr_in_if.sink           in_ch,
  sfr_out_if.source        out_ch,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WCNT_W = $clog2(MAX_PATTERN + 1);

  // Configuration registers
  logic [LEN_W-1:0]      pat_len_r;
  logic [CFG_DATA_W-1:0] pat_chars_r;
  logic [LEN_W-1:0]      sub_len_r;
  logic [CFG_DATA_W-1:0] sub_chars_r;

  // Match window
  char_t             win_r   [MAX_PATTERN];
  char_t             win_nxt [MAX_PATTERN];
  logic [WCNT_W-1:0] win_cnt_r, win_cnt_nxt;

  // Result buffer, head at entry 0
  res_entry_t           buf_r   [OUT_DEPTH];
  res_entry_t           buf_nxt [OUT_DEPTH];
  logic [OUT_CNT_W-1:0] buf_cnt_r, buf_cnt_nxt;

  logic                 in_xfer, out_xfer;
  logic [WCNT_W-1:0]    p_eff, seq_len, dsel;
  logic [LEN_W-1:0]     s_eff;
  char_t                seq [MAX_PATTERN];
  logic [MAX_PATTERN:0] ok;
  logic                 passthru, full_match;
  logic [OUT_CNT_W-1:0] n_emit;
  res_entry_t           load [OUT_DEPTH];
  logic [OUT_CNT_W-1:0] load_cnt;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  // Accept when the buffer is empty or drains its last entry this cycle
  assign in_ch.ready = (buf_cnt_r == '0) ||
                       ((buf_cnt_r == OUT_CNT_W'(1)) && out_ch.ready);

  // Saturated lengths
  assign p_eff = (pat_len_r > LEN_W'(MAX_PATTERN)) ? WCNT_W'(MAX_PATTERN)
                                                    : WCNT_W'(pat_len_r);
  assign s_eff = (sub_len_r > LEN_W'(SUBST_MAX)) ? LEN_W'(SUBST_MAX) : sub_len_r;

  // Held characters followed by the new one
  assign seq_len = win_cnt_r + WCNT_W'(1);
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (WCNT_W'(j) < win_cnt_r) begin
        seq[j] = win_r[j];
      end else if (WCNT_W'(j) == win_cnt_r) begin
        seq[j] = in_ch.in_char;
      end else begin
        seq[j] = '0;
      end
    end
  end

  // ok[d]: the sequence with its first d characters dropped is a needle prefix
  always_comb begin
    for (int d = 0; d <= MAX_PATTERN; d++) begin
      ok[d] = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (d + k < MAX_PATTERN) begin
          if ((WCNT_W'(d + k) < seq_len) &&
              (seq[d + k] != pat_chars_r[CHAR_W*k +: CHAR_W])) begin
            ok[d] = 1'b0;
          end
        end
      end
    end
  end

  assign passthru   = (p_eff == '0);
  assign full_match = !passthru && (seq_len == p_eff) && ok[0];

  // Smallest drop count that leaves a live prefix
  always_comb begin
    dsel = seq_len;
    for (int d = MAX_PATTERN; d >= 0; d--) begin
      if ((WCNT_W'(d) <= seq_len) && ok[d]) begin
        dsel = WCNT_W'(d);
      end
    end
  end

  // Next window: remaining characters shifted to the front
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_nxt[k] = '0;
      for (int d = 0; d < MAX_PATTERN; d++) begin
        if ((d + k < MAX_PATTERN) && (dsel == WCNT_W'(d))) begin
          win_nxt[k] = seq[d + k];
        end
      end
    end
    if (passthru || full_match || in_ch.in_last) begin
      win_cnt_nxt = '0;
    end else begin
      win_cnt_nxt = seq_len - dsel;
    end
  end

  // Results of this item: replacement, or the leading characters of the sequence
  always_comb begin
    if (full_match) begin
      n_emit = OUT_CNT_W'(s_eff);
    end else if (passthru || in_ch.in_last) begin
      n_emit = OUT_CNT_W'(seq_len);
    end else begin
      n_emit = OUT_CNT_W'(dsel);
    end
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (full_match) begin
        load[i].ch = sub_chars_r[CHAR_W*i +: CHAR_W];
      end else if (i < MAX_PATTERN) begin
        load[i].ch = seq[i];
      end else begin
        load[i].ch = '0;
      end
      load[i].valid = 1'b1;
      load[i].last  = in_ch.in_last && (OUT_CNT_W'(i + 1) == n_emit);
    end
    load_cnt = n_emit;
    // End of text with nothing to show: empty marker
    if (in_ch.in_last && (n_emit == '0)) begin
      load[0].ch    = '0;
      load[0].valid = 1'b0;
      load[0].last  = 1'b1;
      load_cnt      = OUT_CNT_W'(1);
    end
  end

  // Buffer load or shift
  always_comb begin
    buf_nxt     = buf_r;
    buf_cnt_nxt = buf_cnt_r;
    if (in_xfer) begin
      buf_nxt     = load;
      buf_cnt_nxt = load_cnt;
    end else if (out_xfer) begin
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      buf_cnt_nxt = buf_cnt_r - OUT_CNT_W'(1);
    end
  end

  assign out_ch.valid     = (buf_cnt_r != '0);
  assign out_ch.out_char  = buf_r[0].ch;
  assign out_ch.out_valid = buf_r[0].valid;
  assign out_ch.out_last  = buf_r[0].last;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      win_cnt_r <= '0;
    end else begin
      buf_cnt_r <= buf_cnt_nxt;
      if (in_xfer) begin
        win_cnt_r <= win_cnt_nxt;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else if (in_xfer) begin
      win_r <= win_nxt;
    end
  end

  // Register writes, ignored while characters are held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      pat_chars_r <= '0;
      sub_len_r   <= '0;
      sub_chars_r <= '0;
    end else if (cfg_we && (win_cnt_r == '0)) begin
      unique case (cfg_idx)
        REG_PATTERN_LEN:   pat_len_r   <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_CHARS: pat_chars_r <= cfg_wdata;
        REG_SUBST_LEN:     sub_len_r   <= cfg_wdata[LEN_W-1:0];
        REG_SUBST_CHARS:   sub_chars_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_check.sv -----
// Port-level assertions for stream_find_replace, attached by bind.
// Depends on sfr_pkg and the top level's channel ports.
`default_nettype none

module sfr_check import sfr_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  in_last,
  input logic  out_valid,
  input logic  out_ready,
  input char_t out_char,
  input logic  out_flag,
  input logic  out_last
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
                                $stable(out_flag) && $stable(out_last))
    else $error("stalled result changed");

  // Empty marker is zero and ends the text
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flag |-> out_last && (out_char == '0))
    else $error("bad empty marker");

  // End of text always yields a result next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result for end of text");

  // Input is held off while the result side is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind stream_find_replace sfr_check u_sfr_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_flag  (out_ch.out_valid),
  .out_last  (out_ch.out_last)
);

`default_nettype wire

// ----- tb/stream_find_replace_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for stream_find_replace: directed and random texts,
// random flow control on both channels, results checked against a built-in predictor.
// Depends on sfr_pkg, the channel interfaces in sfr_if.sv and the block itself.

module stream_find_replace_tb;
  import sfr_pkg::*;

  localparam int NEEDLE_MAX = 4;

  // Predictor of the rewritten text plus the queue of characters still owed
  class text_rewrite_board;
    logic [2:0]  needle_len;
    logic [63:0] needle;
    logic [2:0]  repl_len;
    logic [63:0] repl;
    char_t       held[NEEDLE_MAX];
    int          held_cnt;
    res_entry_t  batch[$];
    res_entry_t  expected_text[$];
    int          errors;
    int          results_checked;

    function new();
      needle_len = '0;
      needle     = '0;
      repl_len   = '0;
      repl       = '0;
      foreach (held[i]) held[i] = '0;
      held_cnt        = 0;
      errors          = 0;
      results_checked = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Register writes land only while no characters are held
    function void write_reg(cfg_idx_t idx, logic [63:0] v);
      if (held_cnt != 0) return;
      case (idx)
        REG_PATTERN_LEN:   needle_len = v[2:0];
        REG_PATTERN_CHARS: needle     = v;
        REG_SUBST_LEN:     repl_len   = v[2:0];
        REG_SUBST_CHARS:   repl       = v;
        default: ;
      endcase
    endfunction

    function char_t lane(logic [63:0] word, int i);
      return word[16*i +: 16];
    endfunction

    function void emit(char_t c);
      res_entry_t e;
      e.ch    = c;
      e.valid = 1'b1;
      e.last  = 1'b0;
      batch.push_back(e);
    endfunction

    function bit is_prefix(int cnt);
      for (int i = 0; i < cnt; i++)
        if (held[i] != lane(needle, i)) return 1'b0;
      return 1'b1;
    endfunction

    function void drop_oldest();
      for (int i = 1; i < held_cnt; i++) held[i-1] = held[i];
      held_cnt--;
    endfunction

    function void flush_held();
      while (held_cnt > 0) begin
        emit(held[0]);
        drop_oldest();
      end
    endfunction

    // Work out what one accepted character produces and queue it
    function void predict_rewrite(char_t c, logic last);
      int         p;
      int         s;
      res_entry_t marker;
      p = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
      s = (repl_len > SUBST_MAX) ? SUBST_MAX : int'(repl_len);
      batch.delete();
      if (p == 0 || held_cnt >= p) begin
        flush_held();
        emit(c);
      end else begin
        held[held_cnt] = c;
        held_cnt++;
        if (held_cnt == p && is_prefix(p)) begin
          for (int i = 0; i < s; i++) emit(lane(repl, i));
          held_cnt = 0;
        end else begin
          while (held_cnt > 0 && !is_prefix(held_cnt)) begin
            emit(held[0]);
            drop_oldest();
          end
        end
      end
      if (last) begin
        flush_held();
        if (batch.size() == 0) begin
          // end of text with nothing to show: empty marker
          marker.ch    = '0;
          marker.valid = 1'b0;
          marker.last  = 1'b1;
          batch.push_back(marker);
        end else begin
          batch[batch.size()-1].last = 1'b1;
        end
      end
      foreach (batch[i]) expected_text.push_back(batch[i]);
    endfunction

    task check_result(char_t ch, logic v, logic l);
      res_entry_t want;
      results_checked++;
      if (expected_text.size() == 0) begin
        report($sformatf("result with nothing expected: char=%h valid=%b last=%b", ch, v, l));
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch)
        report($sformatf("out_char %h, expected %h", ch, want.ch));
      if (v !== want.valid)
        report($sformatf("out_valid %b, expected %b", v, want.valid));
      if (l !== want.last)
        report($sformatf("out_last %b, expected %b", l, want.last));
    endtask

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_idx   = REG_PATTERN_LEN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  sink_ready = 1'b0;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  stream_find_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  text_rewrite_board board;

  int          items_sent    = 0;
  int          texts_sent    = 0;
  int          settings_used = 0;
  logic [63:0] cur_needle    = '0;
  int          cur_plen      = 0;
  char_t       alpha[3];
  int          hold_left     = 0;
  bit          long_hold_done = 1'b0;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random gap, except inside a quiet window of transfer counts
  function automatic bit pause_now(int count, int lo, int hi);
    if (count >= lo && count < hi) return 1'b0;
    return $urandom_range(0, 99) < 35;
  endfunction

  // Result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && sink_ready)
      board.check_result(out_ch.out_char, out_ch.out_valid, out_ch.out_last);
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      sink_ready <= 1'b0;
    end else if (!long_hold_done && board.results_checked >= 45) begin
      // long back-pressure so the block fills and stalls its input
      long_hold_done = 1'b1;
      hold_left = 80;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= !pause_now(board.results_checked, 60, 90);
    end
  end

  task automatic send_item(char_t c, logic l);
    while (pause_now(items_sent, 60, 85)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    in_ch.in_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.predict_rewrite(c, l);
    items_sent++;
  endtask

  task automatic send_text(input char_t txt[$]);
    foreach (txt[k]) send_item(txt[k], k == txt.size() - 1);
    texts_sent++;
  endtask

  // Stop sending and let every owed result drain before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(logic [63:0] plen_v, logic [63:0] pat_v,
                               logic [63:0] slen_v, logic [63:0] sub_v);
    cfg_idx_t    order[4];
    logic [63:0] vals[4];
    order = '{REG_PATTERN_LEN, REG_PATTERN_CHARS, REG_SUBST_LEN, REG_SUBST_CHARS};
    vals  = '{plen_v, pat_v, slen_v, sub_v};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= order[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
      board.write_reg(order[k], vals[k]);
    end
    cfg_we <= 1'b0;
    cur_needle = pat_v;
    cur_plen   = (plen_v[2:0] > NEEDLE_MAX) ? NEEDLE_MAX : int'(plen_v[2:0]);
    settings_used++;
  endtask

  // New needle drawn from a small random alphabet so matches are common
  task automatic random_setting();
    logic [63:0] plen_v, slen_v, pat_v, sub_v;
    int          r;
    foreach (alpha[k]) alpha[k] = char_t'($urandom);
    r = $urandom_range(0, 11);
    plen_v = {$urandom, $urandom};
    if (r == 0)      plen_v[2:0] = 3'd0;
    else if (r < 10) plen_v[2:0] = 3'((r - 1) % 4 + 1);
    else             plen_v[2:0] = 3'($urandom_range(5, 7));
    slen_v = {$urandom, $urandom};
    slen_v[2:0] = 3'($urandom_range(0, 7));
    pat_v = {$urandom, $urandom};
    for (int k = 0; k < NEEDLE_MAX; k++)
      if ($urandom_range(0, 3) != 0) pat_v[16*k +: 16] = alpha[$urandom_range(0, 2)];
    sub_v = {$urandom, $urandom};
    apply_setting(plen_v, pat_v, slen_v, sub_v);
  endtask

  // Mix of whole needles, partial needles, alphabet and arbitrary characters
  task automatic send_random_text();
    char_t txt[$];
    int    len, r, cut;
    len = $urandom_range(1, 10);
    while (txt.size() < len) begin
      r = $urandom_range(0, 9);
      if (r < 4 && cur_plen != 0) begin
        cut = (r == 0) ? $urandom_range(1, cur_plen) : cur_plen;
        for (int k = 0; k < cut; k++) txt.push_back(cur_needle[16*k +: 16]);
      end else if (r < 9) begin
        txt.push_back(alpha[$urandom_range(0, 2)]);
      end else begin
        txt.push_back(char_t'($urandom));
      end
    end
    send_text(txt);
  endtask

  // Main stimulus
  initial begin
    char_t txt[$];
    board = new();
    in_ch.valid   <= 1'b0;
    in_ch.in_char <= '0;
    in_ch.in_last <= 1'b0;
    foreach (alpha[k]) alpha[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: plain passthrough, extreme characters
    txt = '{16'h0000, 16'hFFFF};
    send_text(txt);

    // Two-character needle, three-character replacement
    settle();
    apply_setting(64'd2, 64'h0000_0000_0042_0041, 64'd3, 64'h0000_007A_0079_0078);
    txt = '{16'h0063, 16'h0041, 16'h0042, 16'h0064};
    send_text(txt);
    txt = '{16'h0041, 16'h0041, 16'h0042};   // false start, then match
    send_text(txt);
    txt = '{16'h0041, 16'h0042, 16'h0041};   // held prefix flushed at end
    send_text(txt);
    txt = '{16'h0041};
    send_text(txt);

    // Full needle, empty replacement: needle text becomes an empty marker, prefix flushed
    settle();
    apply_setting(64'd4, 64'h1234_FFFF_0000_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    txt = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234};
    send_text(txt);
    txt = '{16'hFFFF, 16'h0000, 16'hFFFF};
    send_text(txt);

    // Oversized lengths saturate to four
    settle();
    apply_setting(64'd7, 64'h0004_0003_0002_0001, 64'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    txt = '{16'h0001, 16'h0002, 16'h0003, 16'h0004};
    send_text(txt);

    // Random settings and texts, about a hundred characters in all
    while (items_sent < 100) begin
      settle();
      random_setting();
      repeat ($urandom_range(2, 4)) send_random_text();
    end

    // Drain and finish
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d characters in %0d texts under %0d register settings,",
             items_sent, texts_sent, settings_used);
    $display("with %0d results checked and %0d mismatches.", board.results_checked,
             board.errors);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still owed", board.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
